@@ sv/ssp_pkg.sv @@
// Shared constants, payload types and state codes of the shortest path block.
`default_nettype none
package ssp_pkg;

   // Sizing of the block.
   localparam int MAX_VERTICES = 64;
   localparam int MAX_EDGES    = 512;
   localparam int WEIGHT_W     = 16;
   localparam int DIST_W       = 24;

   // Derived widths.
   localparam int VTX_W    = $clog2(MAX_VERTICES);
   localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
   localparam int EDGE_AW  = $clog2(MAX_EDGES);
   localparam int ECNT_W   = $clog2(MAX_EDGES + 1);

   localparam logic [DIST_W-1:0] DIST_INF    = '1;
   localparam logic [DIST_W-1:0] DIST_MAXFIN = DIST_INF - DIST_W'(1);

   // Command codes.
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_RUN   = 2'd2;

   // Status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_EDGE  = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_BAD_START = 2'd3;

   // Result kinds.
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_DIST   = 1'b1;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [VTX_W-1:0]    src_vertex;
      logic [VTX_W-1:0]    dst_vertex;
      logic [WEIGHT_W-1:0] edge_weight_in;
      logic [VTX_W-1:0]    start_vertex;
   } req_word_type;

   typedef struct packed {
      logic                kind;
      logic [VTX_W-1:0]    vertex;
      logic [DIST_W-1:0]   distance;
      logic                reachable;
      logic [1:0]          status;
      logic                last;
   } rsp_word_type;

   // One entry of the edge memory.
   typedef struct packed {
      logic [VTX_W-1:0]    src;
      logic [VTX_W-1:0]    dst;
      logic [WEIGHT_W-1:0] weight;
   } edge_entry_type;

   // One entry of the vertex memory: visited mark and current distance.
   typedef struct packed {
      logic              visited;
      logic [DIST_W-1:0] path_dist;
   } vtx_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_MARK,
      ST_EDGE,
      ST_OUT_RD,
      ST_OUT_LD
   } state_type;

endpackage
`default_nettype wire

@@ sv/ssp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/single_source_shortest_path.sv @@
// Top level of the single source shortest path block: sequencer and memories.
`default_nettype none
// Usage
// The request channel (req_valid, req_stall, req_data) takes one word per command:
// clear the edge table, add an edge, or run from a start vertex. The response
// channel (rsp_valid, rsp_stall, rsp_data) returns one status word for clear, add
// and a rejected run, and one distance word per vertex, in index order with last
// set on the final one, for an accepted run. Command code 3 is taken and dropped.
// The csr_ port writes the vertex count; write it only while the block is idle.
// Clear and add leave the block idle; a new word is taken on the next cycle if the output register is free.
// A run of n vertices over E stored edges first initialises the vertex memory,
// then in each pass scans for the nearest unvisited vertex, marks it and relaxes
// its outgoing edges, for at most n - 1 passes, and finally reads out one
// distance word per vertex. The single read port of the vertex memory sets the scan
// length, and the edge memory is streamed at one edge per cycle with a forwarded write-back.
// Reset sets the vertex count to its maximum and empties the edge table; the
// memories need no clearing. When the receiver stalls, the output register
// holds its word and the sequencer waits; a new request is taken only when idle
// and the output register is free or being emptied in the same cycle.
module single_source_shortest_path (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ssp_pkg::req_word_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output ssp_pkg::rsp_word_type      rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [6:0]            csr_wdata
);
   import ssp_pkg::*;

   // Control state.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   vcount_ff, vcount_in;
   logic [ECNT_W-1:0]  edges_ff, edges_in;
   logic [VTX_W-1:0]   start_ff, start_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   pass_ff, pass_in;
   logic [ECNT_W-1:0]  eidx_ff, eidx_in;
   logic               sc_valid_ff, sc_valid_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               s2_valid_ff, s2_valid_in;
   logic               fw_valid_ff, fw_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [VTX_W-1:0]    sc_idx_ff, sc_idx_in;
   logic [DIST_W-1:0]   best_d_ff, best_d_in;
   logic [VTX_W-1:0]    best_idx_ff, best_idx_in;
   logic [VTX_W-1:0]    s2_v_ff, s2_v_in;
   logic [WEIGHT_W-1:0] s2_w_ff, s2_w_in;
   logic [VTX_W-1:0]    fw_addr_ff, fw_addr_in;
   vtx_entry_type       fw_data_ff, fw_data_in;
   rsp_word_type        rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic                 edge_we, edge_re;
   logic [EDGE_AW-1:0]   edge_wa, edge_ra;
   edge_entry_type       edge_wd, edge_rd;
   logic                 vtx_we, vtx_re;
   logic [VTX_W-1:0]     vtx_wa, vtx_ra;
   vtx_entry_type        vtx_wd, vtx_rd;

   // Relaxation datapath.
   vtx_entry_type        cur_ent;
   logic [DIST_W:0]      relax_sum;
   logic [DIST_W-1:0]    relax_dist;

   logic                 out_free;
   logic                 req_accept;

   ssp_ram #(
      .WIDTH ($bits(edge_entry_type)),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_wa),
      .wr_data (edge_wd),
      .rd_en   (edge_re),
      .rd_addr (edge_ra),
      .rd_data (edge_rd)
   );

   ssp_ram #(
      .WIDTH ($bits(vtx_entry_type)),
      .DEPTH (MAX_VERTICES)
   ) u_vtx_ram (
      .clock   (clock),
      .wr_en   (vtx_we),
      .wr_addr (vtx_wa),
      .wr_data (vtx_wd),
      .rd_en   (vtx_re),
      .rd_addr (vtx_ra),
      .rd_data (vtx_rd)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;

   // The vertex memory is read-first, so a write-back made in the previous
   // cycle to the same vertex is taken from the forwarding register instead.
   assign cur_ent    = (fw_valid_ff && (fw_addr_ff == s2_v_ff)) ? fw_data_ff : vtx_rd;
   assign relax_sum  = {1'b0, best_d_ff} + (DIST_W + 1)'(s2_w_ff);
   assign relax_dist = (relax_sum > {1'b0, DIST_MAXFIN}) ? DIST_MAXFIN
                                                         : relax_sum[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= CNT_W'(MAX_VERTICES);
         edges_ff     <= '0;
         sc_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         fw_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         edges_ff     <= edges_in;
         sc_valid_ff  <= sc_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         fw_valid_ff  <= fw_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff    <= start_in;
      idx_ff      <= idx_in;
      pass_ff     <= pass_in;
      eidx_ff     <= eidx_in;
      sc_idx_ff   <= sc_idx_in;
      best_d_ff   <= best_d_in;
      best_idx_ff <= best_idx_in;
      s2_v_ff     <= s2_v_in;
      s2_w_ff     <= s2_w_in;
      fw_addr_ff  <= fw_addr_in;
      fw_data_ff  <= fw_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      edges_in     = edges_ff;
      start_in     = start_ff;
      idx_in       = idx_ff;
      pass_in      = pass_ff;
      eidx_in      = eidx_ff;
      sc_valid_in  = 1'b0;
      s1_valid_in  = 1'b0;
      s2_valid_in  = 1'b0;
      fw_valid_in  = 1'b0;
      sc_idx_in    = sc_idx_ff;
      best_d_in    = best_d_ff;
      best_idx_in  = best_idx_ff;
      s2_v_in      = s2_v_ff;
      s2_w_in      = s2_w_ff;
      fw_addr_in   = fw_addr_ff;
      fw_data_in   = fw_data_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      edge_we = 1'b0;
      edge_wa = edges_ff[EDGE_AW-1:0];
      edge_wd = '{src: req_data.src_vertex, dst: req_data.dst_vertex,
                  weight: req_data.edge_weight_in};
      edge_re = 1'b0;
      edge_ra = eidx_ff[EDGE_AW-1:0];
      vtx_we  = 1'b0;
      vtx_wa  = idx_ff[VTX_W-1:0];
      vtx_wd  = '0;
      vtx_re  = 1'b0;
      vtx_ra  = idx_ff[VTX_W-1:0];

      // The vertex count register; out-of-range values are clamped.
      if (csr_we) begin
         if (csr_wdata == 7'd0) begin
            vcount_in = CNT_W'(1);
         end else if (CNT_W'(csr_wdata) > CNT_W'(MAX_VERTICES)) begin
            vcount_in = CNT_W'(MAX_VERTICES);
         end else begin
            vcount_in = CNT_W'(csr_wdata);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_data_in = '{kind: KIND_STATUS, vertex: '0, distance: '0,
                               reachable: 1'b0, status: STATUS_OK, last: 1'b1};
               case (req_data.cmd)
                  CMD_CLEAR: begin
                     edges_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_ADD: begin
                     rsp_valid_in = 1'b1;
                     if ((CNT_W'(req_data.src_vertex) >= vcount_ff) ||
                         (CNT_W'(req_data.dst_vertex) >= vcount_ff)) begin
                        rsp_data_in.status = STATUS_BAD_EDGE;
                     end else if (edges_ff == ECNT_W'(MAX_EDGES)) begin
                        rsp_data_in.status = STATUS_FULL;
                     end else begin
                        edge_we  = 1'b1;
                        edges_in = edges_ff + ECNT_W'(1);
                     end
                  end
                  CMD_RUN: begin
                     if (CNT_W'(req_data.start_vertex) >= vcount_ff) begin
                        rsp_data_in.status = STATUS_BAD_START;
                        rsp_valid_in       = 1'b1;
                     end else begin
                        start_in = req_data.start_vertex;
                        idx_in   = '0;
                        state_in = ST_INIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Every vertex in use starts unvisited and unreachable, but the start.
         ST_INIT: begin
            vtx_we = 1'b1;
            vtx_wd.visited   = 1'b0;
            vtx_wd.path_dist = (idx_ff[VTX_W-1:0] == start_ff) ? '0 : DIST_INF;
            idx_in = idx_ff + CNT_W'(1);
            if (idx_ff + CNT_W'(1) == vcount_ff) begin
               pass_in   = '0;
               idx_in    = '0;
               best_d_in = DIST_INF;
               state_in  = (vcount_ff == CNT_W'(1)) ? ST_OUT_RD : ST_SCAN;
            end
         end

         // Stream the vertex memory and keep the first smallest unvisited one.
         ST_SCAN: begin
            if (idx_ff != vcount_ff) begin
               vtx_re      = 1'b1;
               sc_valid_in = 1'b1;
               sc_idx_in   = idx_ff[VTX_W-1:0];
               idx_in      = idx_ff + CNT_W'(1);
            end
            if (sc_valid_ff && !vtx_rd.visited && (vtx_rd.path_dist < best_d_ff)) begin
               best_d_in   = vtx_rd.path_dist;
               best_idx_in = sc_idx_ff;
            end
            if ((idx_ff == vcount_ff) && !sc_valid_ff) begin
               idx_in   = '0;
               state_in = (best_d_ff == DIST_INF) ? ST_OUT_RD : ST_MARK;
            end
         end

         ST_MARK: begin
            vtx_we           = 1'b1;
            vtx_wa           = best_idx_ff;
            vtx_wd.visited   = 1'b1;
            vtx_wd.path_dist = best_d_ff;
            eidx_in          = '0;
            state_in         = ST_EDGE;
         end

         // Three-stage edge stream: read edge, read target vertex, write back.
         ST_EDGE: begin
            if (eidx_ff != edges_ff) begin
               edge_re     = 1'b1;
               s1_valid_in = 1'b1;
               eidx_in     = eidx_ff + ECNT_W'(1);
            end
            if (s1_valid_ff && (edge_rd.src == best_idx_ff) &&
                (CNT_W'(edge_rd.dst) < vcount_ff)) begin
               vtx_re      = 1'b1;
               vtx_ra      = edge_rd.dst;
               s2_valid_in = 1'b1;
               s2_v_in     = edge_rd.dst;
               s2_w_in     = edge_rd.weight;
            end
            if (s2_valid_ff && !cur_ent.visited && (relax_dist < cur_ent.path_dist)) begin
               vtx_we           = 1'b1;
               vtx_wa           = s2_v_ff;
               vtx_wd.visited   = 1'b0;
               vtx_wd.path_dist = relax_dist;
               fw_valid_in      = 1'b1;
               fw_addr_in       = s2_v_ff;
               fw_data_in       = '{visited: 1'b0, path_dist: relax_dist};
            end
            if ((eidx_ff == edges_ff) && !s1_valid_ff && !s2_valid_ff) begin
               pass_in   = pass_ff + CNT_W'(1);
               idx_in    = '0;
               best_d_in = DIST_INF;
               if ((CNT_W + 1)'(pass_ff) + (CNT_W + 1)'(2) < (CNT_W + 1)'(vcount_ff)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_OUT_RD;
               end
            end
         end

         ST_OUT_RD: begin
            vtx_re   = 1'b1;
            state_in = ST_OUT_LD;
         end

         // The read data stays put until the output register is free.
         ST_OUT_LD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{kind: KIND_DIST, vertex: idx_ff[VTX_W-1:0],
                                distance: vtx_rd.path_dist,
                                reachable: (vtx_rd.path_dist != DIST_INF),
                                status: STATUS_OK,
                                last: (idx_ff + CNT_W'(1) == vcount_ff)};
               idx_in = idx_ff + CNT_W'(1);
               if (idx_ff + CNT_W'(1) == vcount_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_OUT_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
